// ===== sv/deq_pkg.sv =====
// Package for the double-ended queue: transaction structs, operation and
// status codes, cell control struct and default sizes.
// Depends on nothing; every other file refers to it by scoped names.
`default_nettype none

package deq_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int VALUE_WIDTH_DEF = 64;

  localparam int FUNC_W   = 3;
  localparam int WORD_W   = 64;
  localparam int COUNT_W  = 5;
  localparam int STATUS_W = 2;

  // Operation codes carried in the func field.
  localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [FUNC_W-1:0] OP_REVERSE    = 3'd4;
  localparam logic [FUNC_W-1:0] OP_PEEK       = 3'd5;

  // Status codes reported with every result.
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [WORD_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [WORD_W-1:0]   front_value;
    logic [WORD_W-1:0]   back_value;
    logic [COUNT_W-1:0]  item_count;
    logic                is_empty;
    logic [STATUS_W-1:0] status;
  } rsp_t;

  // Broadcast to every cell of the chain for one clock.
  typedef struct packed {
    logic shift_up;    // every cell takes its lower neighbour, cell 0 the new value
    logic shift_down;  // every cell takes its upper neighbour
    logic write_end;   // the cell just past the occupied run takes the new value
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/deq_cell.sv =====
// One storage cell of the queue chain. Holds one word, takes a neighbour's word
// on a shift and drives its word onto the tail output when it is the far end of the run.
// Depends on deq_pkg.
`default_nettype none

module deq_cell #(
  parameter int DEPTH       = deq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF,
  parameter int INDEX       = 0
) (
  input  wire                              clk,
  input  wire deq_pkg::cell_ctrl_t         ctrl,
  input  wire [$clog2(DEPTH+1)-1:0]        count,
  input  wire [VALUE_WIDTH-1:0]            value,
  input  wire [VALUE_WIDTH-1:0]            lower,
  input  wire [VALUE_WIDTH-1:0]            upper,
  output logic [VALUE_WIDTH-1:0]           data,
  output logic [VALUE_WIDTH-1:0]           tail
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] IDX      = CW'(INDEX);
  localparam logic [CW-1:0] IDX_NEXT = CW'(INDEX + 1);

  always_ff @(posedge clk) begin
    if (ctrl.shift_up) begin
      data <= lower;
    end else if (ctrl.shift_down) begin
      data <= upper;
    end else if (ctrl.write_end && (count == IDX)) begin
      data <= value;
    end
  end

  // Only the last occupied cell drives its word onto the tail bus.
  assign tail = (count == IDX_NEXT) ? data : '0;

endmodule

`default_nettype wire

// ===== sv/double_ended_queue_unit.sv =====
// Top level of the double-ended queue: control, count, direction flag,
// the chain of deq_cell instances and the result register.
// Depends on deq_pkg and deq_cell.
//
//   channel | direction | payload        | handshake
//   req     | in        | deq_pkg::req_t | req_valid / req_stall
//   rsp     | out       | deq_pkg::rsp_t | rsp_valid / rsp_stall
//
// In a transaction the chain shifts or writes at the accepting edge, and the
// result register reads both ends of the chain once the result side is free.
// No new request is taken until the result of the last one has been loaded.
// Reset (rst, synchronous) empties the queue and clears the direction flag;
// the cell contents are left as they are and are never read before written.
// A stalled result holds in its register; req_stall is high while a result waits to load.
`default_nettype none

module double_ended_queue_unit #(
  parameter int DEPTH       = deq_pkg::DEPTH_DEF,
  parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  wire deq_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output deq_pkg::rsp_t       rsp
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

  logic [CW-1:0]                count;
  logic [CW-1:0]                count_next;
  logic                         rev;
  logic                         rev_next;
  logic                         pending;
  logic [deq_pkg::STATUS_W-1:0] status;
  logic [deq_pkg::STATUS_W-1:0] status_next;

  deq_pkg::cell_ctrl_t   ctrl;
  logic                  accept;
  logic                  load_rsp;
  logic                  full;
  logic                  empty;
  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] cell_data  [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_tail  [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_lower [DEPTH];
  logic [VALUE_WIDTH-1:0] cell_upper [DEPTH];
  logic [VALUE_WIDTH-1:0] end_low;
  logic [VALUE_WIDTH-1:0] end_high;

  assign req_stall = pending;
  assign accept    = req_valid && !pending;
  assign load_rsp  = pending && (!rsp_valid || !rsp_stall);
  assign value     = req.value[VALUE_WIDTH-1:0];
  assign full      = (count == FULL_COUNT);
  assign empty     = (count == '0);

  // Cell 0 is one end of the run and cell count-1 the other; the direction
  // flag says which of the two is the front.
  always_comb begin
    ctrl        = '0;
    count_next  = count;
    rev_next    = rev;
    status_next = deq_pkg::ST_OK;
    case (req.func)
      deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          status_next = deq_pkg::ST_FULL;
        end else begin
          if ((req.func == deq_pkg::OP_PUSH_FRONT) != rev) begin
            ctrl.shift_up = accept;
          end else begin
            ctrl.write_end = accept;
          end
          count_next = count + CW'(1);
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          if ((req.func == deq_pkg::OP_POP_FRONT) != rev) begin
            ctrl.shift_down = accept;
          end
          count_next = count - CW'(1);
        end
      end
      deq_pkg::OP_REVERSE: begin
        if (empty) begin
          status_next = deq_pkg::ST_EMPTY;
        end else begin
          rev_next = !rev;
        end
      end
      default: begin
        status_next = deq_pkg::ST_OK;
      end
    endcase
    if (count_next == '0) begin
      rev_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rev     <= 1'b0;
      pending <= 1'b0;
    end else if (accept) begin
      count   <= count_next;
      rev     <= rev_next;
      pending <= 1'b1;
    end else if (load_rsp) begin
      pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
    end
  end

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_first
        assign cell_lower[g] = value;
      end else begin : g_mid_lo
        assign cell_lower[g] = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign cell_upper[g] = cell_data[g];
      end else begin : g_mid_hi
        assign cell_upper[g] = cell_data[g+1];
      end

      deq_cell #(
        .DEPTH       (DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH),
        .INDEX       (g)
      ) u_cell (
        .clk   (clk),
        .ctrl  (ctrl),
        .count (count),
        .value (value),
        .lower (cell_lower[g]),
        .upper (cell_upper[g]),
        .data  (cell_data[g]),
        .tail  (cell_tail[g])
      );
    end
  endgenerate

  // At most one cell drives a non-zero tail, so an OR collects the far end.
  always_comb begin
    end_high = '0;
    for (int i = 0; i < DEPTH; i++) begin
      end_high = end_high | cell_tail[i];
    end
    end_low = empty ? '0 : cell_data[0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.front_value <= deq_pkg::WORD_W'(rev ? end_high : end_low);
      rsp.back_value  <= deq_pkg::WORD_W'(rev ? end_low : end_high);
      rsp.item_count  <= deq_pkg::COUNT_W'(count);
      rsp.is_empty    <= empty;
      rsp.status      <= status;
    end
  end

endmodule

`default_nettype wire

// ===== sv/deq_checker.sv =====
// Port-level checks on the double-ended queue results, with the bind that
// attaches them to double_ended_queue_unit.
// Depends on deq_pkg.
`default_nettype none

module deq_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 req_valid,
  input wire                 req_stall,
  input wire deq_pkg::req_t  req,
  input wire                 rsp_valid,
  input wire                 rsp_stall,
  input wire deq_pkg::rsp_t  rsp
);

  // The empty mark must agree with the count in every result.
  a_empty_matches_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.is_empty == (rsp.item_count == '0)))
    else $error("is_empty disagrees with item_count");

  // An empty queue shows no values at either end.
  a_empty_ends_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.is_empty) |-> (rsp.front_value == '0 && rsp.back_value == '0))
    else $error("empty queue reports a non-zero end value");

  // With a single value the front and the back are the same word.
  a_single_ends_equal: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.item_count == 5'd1) |-> (rsp.front_value == rsp.back_value))
    else $error("single entry shows different front and back");

  // A result that is held back stays on the port unchanged.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp)))
    else $error("stalled result transaction changed");

  // A request that is held back stays offered and unchanged.
  a_req_hold: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_stall) |=> (req_valid && $stable(req)))
    else $error("stalled request transaction changed");

endmodule

bind double_ended_queue_unit deq_checker u_deq_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req       (req),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp       (rsp)
);

`default_nettype wire
